[hdl/frt_pkg.sv]
// Shared types and constants for the failure retry table.
`timescale 1ns / 1ps
package frt_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ID_W     = 64;
  localparam int TIME_W   = 32;
  localparam int ATT_W    = 8;

  localparam logic [ATT_W-1:0]  ATT_MAX   = {ATT_W{1'b1}};
  localparam logic [ATT_W-1:0]  ATT_ONE   = ATT_W'(1);
  localparam logic [TIME_W-1:0] TIME_ONE  = TIME_W'(1);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] REG_RECHECK = 2'd0;
  localparam logic [1:0] REG_RETRY   = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  localparam logic [TIME_W-1:0] RECHECK_RST = TIME_W'(2000);
  localparam logic [TIME_W-1:0] RETRY_RST   = TIME_W'(5000);
  localparam logic [ATT_W-1:0]  LIMIT_RST   = ATT_W'(3);

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_FORGET = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FS_NONE  = 2'd0,
    FS_RETRY = 2'd1,
    FS_WAIT  = 2'd2
  } fail_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_e;

  // Match and free-slot result rippling down the cell row.
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [ID_W-1:0]   ident;
    logic [ATT_W-1:0]  attempts;
    logic [TIME_W-1:0] failed_time;
    logic [TIME_W-1:0] checked_time;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
  } carry_t;

  // Update broadcast to the row at the end of an item.
  typedef struct packed {
    logic                en;
    logic                clear_all;
    logic [IDX_W-1:0]    idx;
    logic                upd_valid;
    logic                valid;
    logic                upd_key;
    logic [KEY_BITS-1:0] key;
    logic                upd_entry;
    logic [ID_W-1:0]     ident;
    logic [ATT_W-1:0]    attempts;
    logic [TIME_W-1:0]   failed_time;
    logic                upd_checked;
    logic [TIME_W-1:0]   checked_time;
  } cmd_t;

endpackage

[hdl/frt_cell.sv]
// One table entry with its stage of the match chain.
`timescale 1ns / 1ps
module frt_cell
  import frt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IDX_W-1:0]    cell_idx_i,
  input  logic [KEY_BITS-1:0] probe_key_i,
  input  carry_t              carry_i,
  input  cmd_t                cmd_i,
  output carry_t              carry_o
);

  logic                valid_q;
  logic [KEY_BITS-1:0] key_q;
  logic [ID_W-1:0]     ident_q;
  logic [ATT_W-1:0]    attempts_q;
  logic [TIME_W-1:0]   failed_q;
  logic [TIME_W-1:0]   checked_q;
  carry_t              carry_q;
  carry_t              carry_d;
  logic                sel;

  assign sel = cmd_i.en && (cmd_i.idx == cell_idx_i);

  always_comb begin
    carry_d = carry_i;
    if (!carry_i.hit && valid_q && (key_q == probe_key_i)) begin
      carry_d.hit          = 1'b1;
      carry_d.hit_idx      = cell_idx_i;
      carry_d.ident        = ident_q;
      carry_d.attempts     = attempts_q;
      carry_d.failed_time  = failed_q;
      carry_d.checked_time = checked_q;
    end
    if (!carry_i.free && !valid_q) begin
      carry_d.free     = 1'b1;
      carry_d.free_idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.en && cmd_i.clear_all) begin
      valid_q <= 1'b0;
    end else if (sel && cmd_i.upd_valid) begin
      valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (sel && cmd_i.upd_key) begin
      key_q <= cmd_i.key;
    end
    if (sel && cmd_i.upd_entry) begin
      ident_q    <= cmd_i.ident;
      attempts_q <= cmd_i.attempts;
      failed_q   <= cmd_i.failed_time;
    end
    if (sel && cmd_i.upd_checked) begin
      checked_q <= cmd_i.checked_time;
    end
  end

  assign carry_o = carry_q;

endmodule

[hdl/failure_retry_table_unit.sv]
// Top level of the failure retry table: control, registers and the cell row.
//
// An item (kind, key, file identity, time) is taken at a clock edge where start
// is high and busy is low. The key is then passed along a row of ENTRIES cells,
// one cell per cycle, collecting the first match and the first free slot. The
// update state then applies the update and registers the result.
// done_o is high for exactly one cycle with fail_status_o and entry_found_o;
// it follows the scan through the cell row and then the update state.
// busy drops in the done cycle, so a new item can be taken there; the block
// takes no new item while one is still passing through the cell row.
// The receiver cannot stall; each result must be taken in its done cycle.
// Registers sit on an APB port: recheck_interval at 0x0, retry_interval at
// 0x4, attempt_limit at 0x8; write only while busy is low.
// Reset empties the table, zeroes the eviction pointer and loads the register
// defaults (2000, 5000, 3). No clearing pass follows reset.
`timescale 1ns / 1ps
module failure_retry_table_unit
  import frt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind_i,
  input  logic [63:0]         key_i,
  input  logic [ID_W-1:0]     file_identity_i,
  input  logic [TIME_W-1:0]   now_time_i,
  output logic                done_o,
  output logic [1:0]          fail_status_o,
  output logic                entry_found_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    evict_q, evict_d;
  logic                done_q;
  logic [1:0]          status_q;
  logic                found_q;
  fail_status_e        status_d;
  logic                found_d;
  logic [TIME_W-1:0]   recheck_q;
  logic [TIME_W-1:0]   retry_q;
  logic [ATT_W-1:0]    limit_q;
  kind_e               kind_q;
  logic [KEY_BITS-1:0] key_q;
  logic [ID_W-1:0]     ident_q;
  logic [TIME_W-1:0]   now_q;
  logic                accept;
  logic                cfg_wr;
  carry_t              chain [ENTRIES+1];
  carry_t              res;
  cmd_t                cmd;
  logic                chk_due;
  logic                retry_due;
  logic                id_same;
  logic [ATT_W-1:0]    att_base;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recheck_q <= RECHECK_RST;
      retry_q   <= RETRY_RST;
      limit_q   <= LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RECHECK: recheck_q <= pwdata;
        REG_RETRY:   retry_q   <= pwdata;
        REG_LIMIT:   limit_q   <= pwdata[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RECHECK: prdata = recheck_q;
      REG_RETRY:   prdata = retry_q;
      REG_LIMIT:   prdata = {{(32-ATT_W){1'b0}}, limit_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_e'(kind_i);
      key_q   <= key_i[KEY_BITS-1:0];
      ident_q <= file_identity_i;
      now_q   <= (now_time_i == '0) ? TIME_ONE : now_time_i;
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    frt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IDX_W'(i)),
      .probe_key_i (key_q),
      .carry_i     (chain[i]),
      .cmd_i       (cmd),
      .carry_o     (chain[i+1])
    );
  end

  assign res       = chain[ENTRIES];
  assign chk_due   = (TIME_W'(now_q - res.checked_time) >= recheck_q);
  assign retry_due = (TIME_W'(now_q - res.failed_time) >= retry_q);
  assign id_same   = (res.ident == ident_q);

  always_comb begin
    cmd          = '0;
    cmd.en       = (state_q == S_EXEC);
    cmd.idx      = res.hit_idx;
    cmd.key      = key_q;
    cmd.ident    = ident_q;
    cmd.failed_time  = now_q;
    cmd.checked_time = now_q;
    status_d     = FS_NONE;
    found_d      = 1'b0;
    evict_d      = evict_q;
    att_base     = '0;
    case (kind_q)
      KIND_QUERY: begin
        if (res.hit) begin
          found_d  = 1'b1;
          status_d = FS_WAIT;
          if (chk_due) begin
            cmd.upd_checked = 1'b1;
            if (!id_same) begin
              cmd.upd_valid = 1'b1;
              cmd.valid     = 1'b0;
              status_d      = FS_NONE;
            end
          end
          if (!(chk_due && !id_same) && (res.attempts < limit_q) && retry_due) begin
            status_d = FS_RETRY;
          end
        end
      end
      KIND_RECORD: begin
        cmd.upd_entry   = 1'b1;
        cmd.upd_checked = 1'b1;
        if (res.hit) begin
          found_d  = 1'b1;
          att_base = id_same ? res.attempts : '0;
        end else begin
          cmd.upd_valid = 1'b1;
          cmd.valid     = 1'b1;
          cmd.upd_key   = 1'b1;
          if (res.free) begin
            cmd.idx = res.free_idx;
          end else begin
            cmd.idx = evict_q;
            evict_d = (evict_q == IDX_LAST) ? '0 : evict_q + IDX_W'(1);
          end
        end
        cmd.attempts = (att_base == ATT_MAX) ? ATT_MAX : att_base + ATT_ONE;
      end
      KIND_CLEAR: begin
        if (res.hit) begin
          found_d       = 1'b1;
          cmd.upd_valid = 1'b1;
          cmd.valid     = 1'b0;
        end
      end
      KIND_FORGET: begin
        cmd.clear_all = 1'b1;
        evict_d       = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_LAST) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      evict_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= (state_q == S_EXEC);
      if (state_q == S_EXEC) begin
        evict_q <= evict_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  assign done_o        = done_q;
  assign fail_status_o = status_q;
  assign entry_found_o = found_q;

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("block not busy after taking an item");

  a_exec_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> done_o) else $error("update cycle gave no result");

  a_status_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (kind_q != KIND_QUERY) |-> (fail_status_o == FS_NONE))
    else $error("status set for a non-query item");

  a_forget_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (kind_q == KIND_FORGET) |-> !entry_found_o)
    else $error("forget reported a found entry");

endmodule

[tb/failure_retry_table_checker.sv]
// Checker for the failure retry table: predicts every result and compares it with the block, and checks register reads.
`timescale 1ns / 1ps
module failure_retry_table_checker
  import frt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        kind_i,
  input  logic [63:0]       key_i,
  input  logic [ID_W-1:0]   file_identity_i,
  input  logic [TIME_W-1:0] now_time_i,
  input  logic              done_i,
  input  logic [1:0]        fail_status_i,
  input  logic              entry_found_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                mismatch_count_o,
  output int                results_pending_o
);

  typedef struct packed {
    fail_status_e status;
    logic         found;
  } outcome_t;

  logic                row_valid    [ENTRIES];
  logic [KEY_BITS-1:0] row_key      [ENTRIES];
  logic [ID_W-1:0]     row_ident    [ENTRIES];
  logic [ATT_W-1:0]    row_attempts [ENTRIES];
  logic [TIME_W-1:0]   row_failed   [ENTRIES];
  logic [TIME_W-1:0]   row_checked  [ENTRIES];
  logic [IDX_W-1:0]    evict_idx;

  logic [TIME_W-1:0]   recheck_ms;
  logic [TIME_W-1:0]   retry_ms;
  logic [ATT_W-1:0]    limit_att;

  outcome_t            expected_outcomes[$];
  int                  mismatches = 0;

  function automatic outcome_t predict_outcome(kind_e kind, logic [KEY_BITS-1:0] key,
                                               logic [ID_W-1:0] ident,
                                               logic [TIME_W-1:0] now_raw);
    outcome_t          res;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] since_check;
    logic [TIME_W-1:0] since_fail;
    int                slot;
    int                n;
    slot       = -1;
    res.status = FS_NONE;
    res.found  = 1'b0;
    now        = (now_raw == '0) ? TIME_ONE : now_raw;
    for (n = ENTRIES - 1; n >= 0; n--) begin
      if (row_valid[n] && row_key[n] == key) slot = n;
    end
    case (kind)
      KIND_QUERY: begin
        if (slot >= 0) begin
          res.found   = 1'b1;
          res.status  = FS_WAIT;
          since_check = now - row_checked[slot];
          if (since_check >= recheck_ms) begin
            row_checked[slot] = now;
            if (row_ident[slot] != ident) begin
              row_valid[slot] = 1'b0;
              res.status      = FS_NONE;
            end
          end
          since_fail = now - row_failed[slot];
          if (row_valid[slot] && row_attempts[slot] < limit_att && since_fail >= retry_ms)
            res.status = FS_RETRY;
        end
      end
      KIND_RECORD: begin
        if (slot >= 0) begin
          res.found = 1'b1;
          if (row_ident[slot] != ident) row_attempts[slot] = '0;
        end else begin
          for (n = ENTRIES - 1; n >= 0; n--) begin
            if (!row_valid[n]) slot = n;
          end
          if (slot < 0) begin
            slot      = int'(evict_idx);
            evict_idx = (evict_idx == IDX_LAST) ? '0 : evict_idx + 1'b1;
          end
          row_valid[slot]    = 1'b1;
          row_key[slot]      = key;
          row_attempts[slot] = '0;
        end
        row_ident[slot] = ident;
        if (row_attempts[slot] != ATT_MAX) row_attempts[slot] = row_attempts[slot] + 1'b1;
        row_failed[slot]  = now;
        row_checked[slot] = now;
      end
      KIND_CLEAR: begin
        if (slot >= 0) begin
          res.found       = 1'b1;
          row_valid[slot] = 1'b0;
        end
      end
      default: begin
        row_valid = '{default: 1'b0};
        evict_idx = '0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    outcome_t    head;
    logic [31:0] reg_value;
    logic        reg_known;
    if (!rst_ni) begin
      row_valid  = '{default: 1'b0};
      evict_idx  = '0;
      recheck_ms = RECHECK_RST;
      retry_ms   = RETRY_RST;
      limit_att  = LIMIT_RST;
      expected_outcomes.delete();
      results_pending_o <= 0;
      mismatch_count_o  <= mismatches;
    end else begin
      if (done_i) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t unexpected result: expected none, got fail_status %0d entry_found %0d",
                   $time, fail_status_i, entry_found_i);
          mismatches++;
        end else begin
          head = expected_outcomes.pop_front();
          if (fail_status_i !== head.status) begin
            $display("%0t fail_status mismatch: expected %0d, got %0d",
                     $time, head.status, fail_status_i);
            mismatches++;
          end
          if (entry_found_i !== head.found) begin
            $display("%0t entry_found mismatch: expected %0d, got %0d",
                     $time, head.found, entry_found_i);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        expected_outcomes.push_back(predict_outcome(kind_e'(kind_i), key_i[KEY_BITS-1:0],
                                                    file_identity_i, now_time_i));
      if (psel && penable && pready) begin
        reg_known = 1'b1;
        case (paddr[3:2])
          REG_RECHECK: reg_value = recheck_ms;
          REG_RETRY:   reg_value = retry_ms;
          REG_LIMIT:   reg_value = 32'(limit_att);
          default: begin
            reg_value = '0;
            reg_known = 1'b0;
          end
        endcase
        if (pwrite) begin
          case (paddr[3:2])
            REG_RECHECK: recheck_ms = pwdata;
            REG_RETRY:   retry_ms   = pwdata;
            REG_LIMIT:   limit_att  = pwdata[ATT_W-1:0];
            default: ;
          endcase
        end else if (reg_known && prdata !== reg_value) begin
          $display("%0t register read mismatch at 0x%0h: expected 0x%0h, got 0x%0h",
                   $time, paddr, reg_value, prdata);
          mismatches++;
        end
      end
      results_pending_o <= expected_outcomes.size();
      mismatch_count_o  <= mismatches;
    end
  end

endmodule

[tb/tb_failure_retry_table_unit.sv]
// Testbench top for the failure retry table: drives items, register writes and reads, gives the verdict.
`timescale 1ns / 1ps
module tb_failure_retry_table_unit;
  import frt_pkg::*;

  localparam int         STALL_LIMIT = 2000;
  localparam int         POOL_SIZE   = 32;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        kind_i;
  logic [63:0]       key_i;
  logic [ID_W-1:0]   file_identity_i;
  logic [TIME_W-1:0] now_time_i;
  logic              done_o;
  logic [1:0]        fail_status_o;
  logic              entry_found_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int                mismatch_count;
  int                results_pending;
  int                quiet_cycles = 0;
  bit                idle_on;
  logic [TIME_W-1:0] clock_ms;
  logic [63:0]       key_pool   [POOL_SIZE];
  logic [ID_W-1:0]   ident_main [POOL_SIZE];
  logic [ID_W-1:0]   ident_alt  [POOL_SIZE];

  failure_retry_table_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .key_i           (key_i),
    .file_identity_i (file_identity_i),
    .now_time_i      (now_time_i),
    .done_o          (done_o),
    .fail_status_o   (fail_status_o),
    .entry_found_o   (entry_found_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  failure_retry_table_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .key_i             (key_i),
    .file_identity_i   (file_identity_i),
    .now_time_i        (now_time_i),
    .done_i            (done_o),
    .fail_status_i     (fail_status_o),
    .entry_found_i     (entry_found_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("failure_retry_table_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(kind_e kind, logic [63:0] key, logic [ID_W-1:0] ident,
                           logic [TIME_W-1:0] now);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    kind_i          <= kind;
    key_i           <= key;
    file_identity_i <= ident;
    now_time_i      <= now;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic apb_access(bit is_write, logic [1:0] reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold off until every result is back and the block is idle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (ENTRIES + 4) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] recheck, logic [31:0] retry, logic [7:0] limit);
    settle();
    apb_access(1'b1, REG_RECHECK, recheck);
    apb_access(1'b1, REG_RETRY, retry);
    apb_access(1'b1, REG_LIMIT, 32'(limit));
    apb_access(1'b1, REG_SPARE, $urandom);
    apb_access(1'b0, REG_RECHECK, '0);
    apb_access(1'b0, REG_RETRY, '0);
    apb_access(1'b0, REG_LIMIT, '0);
  endtask

  // churn_pct sets identity changes and also enables clears, forgets and fresh keys
  task automatic run_phase(int count, int pool_used, int record_pct, int churn_pct,
                           int step_max);
    kind_e             kind;
    int                pick;
    int                slot;
    logic [63:0]       key;
    logic [ID_W-1:0]   ident;
    logic [TIME_W-1:0] now;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, pool_used - 1);
      if (churn_pct > 0 && pick == 0) kind = KIND_FORGET;
      else if (pick < record_pct) kind = KIND_RECORD;
      else if (churn_pct > 0 && pick < record_pct + 10) kind = KIND_CLEAR;
      else kind = KIND_QUERY;
      if (churn_pct > 0 && $urandom_range(0, 19) == 0) key = {$urandom, $urandom};
      else key = key_pool[slot];
      if ($urandom_range(0, 99) >= churn_pct) ident = ident_main[slot];
      else if ($urandom_range(0, 1) == 0) ident = ident_alt[slot];
      else ident = {$urandom, $urandom};
      clock_ms = clock_ms + $urandom_range(0, step_max);
      case ($urandom_range(0, 29))
        0:       now = '0;
        1:       now = $urandom;
        default: now = clock_ms;
      endcase
      send_item(kind, key, ident, now);
    end
  endtask

  initial begin
    int n;
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    kind_i          <= KIND_QUERY;
    key_i           <= '0;
    file_identity_i <= '0;
    now_time_i      <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    idle_on  = 1'b1;
    clock_ms = 32'd20000;
    for (n = 0; n < POOL_SIZE; n++) begin
      key_pool[n]   = {$urandom, $urandom};
      ident_main[n] = {$urandom, $urandom};
      ident_alt[n]  = {$urandom, $urandom};
    end
    key_pool[0]   = '0;
    key_pool[1]   = '1;
    ident_main[0] = '0;
    ident_main[1] = '1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(KIND_QUERY, key_pool[0], '0, 32'd10);
    send_item(KIND_CLEAR, key_pool[0], '0, 32'd20);
    send_item(KIND_RECORD, key_pool[0], '0, '0);
    send_item(KIND_QUERY, key_pool[0], '0, 32'd100);
    send_item(KIND_QUERY, key_pool[0], '0, 32'd5001);
    send_item(KIND_RECORD, key_pool[0], '0, 32'd6000);
    send_item(KIND_RECORD, key_pool[0], '1, 32'd6100);
    send_item(KIND_QUERY, key_pool[0], '0, 32'd9000);
    send_item(KIND_RECORD, key_pool[1], '1, '1);
    send_item(KIND_QUERY, key_pool[1], '1, 32'h0000_1000);
    for (n = 2; n <= 17; n++) send_item(KIND_RECORD, key_pool[n], ident_main[n], 32'h2000);
    send_item(KIND_QUERY, key_pool[1], '1, 32'h2100);
    send_item(KIND_CLEAR, key_pool[2], ident_main[2], 32'h2200);
    send_item(KIND_FORGET, '0, '0, 32'h2300);
    send_item(KIND_QUERY, key_pool[3], ident_main[3], 32'h2400);

    configure(32'd100, 32'd300, 8'd3);
    run_phase(250, 24, 35, 20, 150);
    configure('0, '0, '0);
    run_phase(250, 20, 40, 25, 50);
    configure('1, 32'd30, 8'hFF);
    run_phase(700, 2, 90, 0, 40);
    configure('1, '1, 8'hFF);
    run_phase(150, 20, 40, 20, 100);
    clock_ms = 32'hFFFF_F000;
    configure($urandom_range(0, 400), $urandom_range(0, 800), 8'($urandom_range(1, 5)));
    run_phase(200, 32, 40, 20, 120);
    configure($urandom_range(0, 400), $urandom_range(0, 800), 8'($urandom_range(1, 5)));
    idle_on = 1'b0;
    run_phase(250, 24, 40, 20, 150);
    settle();

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("failure_retry_table_unit test passed");
    end else begin
      $display("failure_retry_table_unit test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/frt_pkg.sv
hdl/frt_cell.sv
hdl/failure_retry_table_unit.sv
tb/failure_retry_table_checker.sv
tb/tb_failure_retry_table_unit.sv
